FILE: sv/assert_macros.svh
// Assertion helpers for the RTL files; plst_core is the one that includes them.
// All checks are disabled while reset is asserted (active low).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Expression holds at every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

FILE: sv/plst_pkg.sv
package plst_pkg;

    // List geometry
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the request and result
    localparam int FUNC_W   = 3;
    localparam int VAL_W    = 32;
    localparam int POS_W    = 8;
    localparam int LEN_W    = 5;
    localparam int STAT_W   = 2;

    // Stream data widths, padded to whole bytes
    localparam int S_RAW_W  = FUNC_W + VAL_W + POS_W;
    localparam int S_DATA_W = ((S_RAW_W + 7) / 8) * 8;
    localparam int M_RAW_W  = VAL_W + STAT_W + LEN_W;
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8;

    // Request opcodes; codes 6 and 7 are no-ops
    typedef enum logic [FUNC_W-1:0] {
        FN_INS_FRONT = 3'd0,
        FN_INS_END   = 3'd1,
        FN_INS_POS   = 3'd2,
        FN_REM_FRONT = 3'd3,
        FN_REM_END   = 3'd4,
        FN_REM_POS   = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

    typedef struct packed {
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
        t_func                   func;
    } t_req;

    typedef struct packed {
        logic [LEN_W-1:0]        length;
        t_status                 status;
        logic signed [VAL_W-1:0] removed_value;
    } t_res;

endpackage

FILE: sv/plst_core.sv
// List storage: shift-register entries plus count, one request per enable.
module plst_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  plst_pkg::t_req   i_req,
    output plst_pkg::t_res   o_res
);

    localparam int CAP   = plst_pkg::CAPACITY;
    localparam int IDX_W = plst_pkg::IDX_W;
    localparam int CNT_W = plst_pkg::CNT_W;
    localparam int POS_W = plst_pkg::POS_W;
    localparam int VAL_W = plst_pkg::VAL_W;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic signed [VAL_W-1:0] r_entries [CAP];
    logic signed [VAL_W-1:0] n_entries [CAP];
    logic signed [VAL_W-1:0] w_prev    [CAP];
    logic signed [VAL_W-1:0] w_next    [CAP];
    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        n_count;

    logic                    w_full;
    logic                    w_empty;
    logic                    w_pos_past;
    logic                    w_do_ins;
    logic                    w_do_rem;
    logic [IDX_W-1:0]        w_at;
    plst_pkg::t_status       w_status;

    assign w_full     = (r_count == CNT_W'(CAP));
    assign w_empty    = (r_count == '0);
    assign w_pos_past = (CMP_W'(i_req.position) >= CMP_W'(r_count));

    // Decode: operation, target slot and status
    always_comb begin
        w_do_ins = 1'b0;
        w_do_rem = 1'b0;
        w_at     = '0;
        w_status = plst_pkg::ST_OK;
        unique case (i_req.func)
            plst_pkg::FN_INS_FRONT: begin
                if (w_full) w_status = plst_pkg::ST_FULL;
                else        w_do_ins = 1'b1;
            end
            plst_pkg::FN_INS_END: begin
                w_at = r_count[IDX_W-1:0];
                if (w_full) w_status = plst_pkg::ST_FULL;
                else        w_do_ins = 1'b1;
            end
            plst_pkg::FN_INS_POS: begin
                // past the end appends
                w_at = w_pos_past ? r_count[IDX_W-1:0] : i_req.position[IDX_W-1:0];
                if (w_full) w_status = plst_pkg::ST_FULL;
                else        w_do_ins = 1'b1;
            end
            plst_pkg::FN_REM_FRONT: begin
                if (w_empty) w_status = plst_pkg::ST_EMPTY;
                else         w_do_rem = 1'b1;
            end
            plst_pkg::FN_REM_END: begin
                w_at = IDX_W'(r_count - CNT_W'(1));
                if (w_empty) w_status = plst_pkg::ST_EMPTY;
                else         w_do_rem = 1'b1;
            end
            plst_pkg::FN_REM_POS: begin
                w_at = i_req.position[IDX_W-1:0];
                if (w_empty)         w_status = plst_pkg::ST_EMPTY;
                else if (w_pos_past) w_status = plst_pkg::ST_BADPOS;
                else                 w_do_rem = 1'b1;
            end
            default: begin
                w_status = plst_pkg::ST_OK;
            end
        endcase
    end

    // Neighbor taps for the shift in either direction
    always_comb begin
        w_prev[0]     = r_entries[0];
        w_next[CAP-1] = r_entries[CAP-1];
        for (int i = 1; i < CAP; i++) begin
            w_prev[i]   = r_entries[i-1];
            w_next[i-1] = r_entries[i];
        end
    end

    // Per-entry next value: open a gap at w_at or close it
    always_comb begin
        for (int i = 0; i < CAP; i++) begin
            n_entries[i] = r_entries[i];
            if (w_do_ins) begin
                if (IDX_W'(i) == w_at)      n_entries[i] = i_req.value;
                else if (IDX_W'(i) > w_at)  n_entries[i] = w_prev[i];
            end else if (w_do_rem) begin
                if (IDX_W'(i) >= w_at)      n_entries[i] = w_next[i];
            end
        end
    end

    // Count update
    always_comb begin
        n_count = r_count;
        if (w_do_ins)      n_count = r_count + CNT_W'(1);
        else if (w_do_rem) n_count = r_count - CNT_W'(1);
    end

    // Result for this request
    always_comb begin
        o_res.removed_value = w_do_rem ? r_entries[w_at] : '0;
        o_res.status        = w_status;
        o_res.length        = plst_pkg::LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_en) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_entries <= n_entries;
        end
    end

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(CAP), "count over capacity")
    `ASSERT_NEXT(a_idle_holds, i_clk, i_rst_n, !i_en, $stable(r_count), "count moved while idle")
    `ASSERT_NEXT(a_refused_holds, i_clk, i_rst_n, i_en && !w_do_ins && !w_do_rem, $stable(r_count), "count moved on refused request")
    `ASSERT_IMPLY(a_removed_ok, i_clk, i_rst_n, o_res.removed_value != '0, o_res.status == plst_pkg::ST_OK, "removed value on failed request")

endmodule

FILE: sv/positional_list_store.sv
// Channel  | Dir | Signals                         | Payload (lowest bit up)
// request  | in  | i_s_axis_tvalid/tready/tdata    | func[2:0] value[34:3] position[42:35]
// result   | out | o_m_axis_tvalid/tready/tdata    | removed_value[31:0] status[33:32]
//          |     |                                 | length[38:34]
//
// One transaction accepted per cycle when the result side keeps up; one result
// per request, passed through the input register and then the result register.
// The list update is a single pass over the shift-register entries, so each
// request sees the list left by the one before it without extra wait.
// Synchronous active-low reset empties the list; no clearing pass.
// A stalled result register holds the input register, and tready drops only
// when both are full.
module positional_list_store (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // func[2:0], value[34:3], position[42:35], zero pad above
    input  logic [plst_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // removed_value[31:0], status[33:32], length[38:34], zero pad above
    output logic [plst_pkg::M_DATA_W-1:0] o_m_axis_tdata
);

    logic             r_in_valid;
    plst_pkg::t_req   r_in;
    logic             r_out_valid;
    plst_pkg::t_res   r_out;
    plst_pkg::t_res   w_res;
    logic             w_advance;
    logic             w_in_ready;

    // Pipeline moves when the result slot is free or being drained
    assign w_advance  = !r_out_valid || i_m_axis_tready;
    assign w_in_ready = !r_in_valid || w_advance;

    plst_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && w_advance),
        .i_req   (r_in),
        .o_res   (w_res)
    );

    // Valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_advance)  r_out_valid <= r_in_valid;
            if (w_in_ready) r_in_valid  <= i_s_axis_tvalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_advance && r_in_valid) begin
            r_out <= w_res;
        end
        if (w_in_ready && i_s_axis_tvalid) begin
            r_in <= plst_pkg::t_req'(i_s_axis_tdata[plst_pkg::S_RAW_W-1:0]);
        end
    end

    assign o_s_axis_tready = w_in_ready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = plst_pkg::M_DATA_W'(r_out);

endmodule
